FILE: rtl/kwm_pkg.sv
// Package for the k-way time merge block: operation and status codes,
// default sizes and the head-table command group. No dependencies.
package kwm_pkg;

  localparam int NUM_TRACKS_DEF  = 16;
  localparam int TRACK_DEPTH_DEF = 256;

  localparam logic [4:0] TRACKS_IN_USE_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_TAKE   = 2'd1,
    OP_REWIND = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ROOT   = 3'd0,
    ST_EVENT  = 3'd1,
    ST_NONE   = 3'd2,
    ST_LOADED = 3'd3,
    ST_FULL   = 3'd4,
    ST_DONE   = 3'd5
  } status_t;

  // update requests to the per-track length / read-position table
  typedef struct packed {
    logic clear;    // zero every length and position
    logic rewind;   // zero every position
    logic inc_len;  // bump length of the addressed track
    logic inc_pos;  // bump position of the addressed track
  } heads_cmd_t;

endpackage

FILE: rtl/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kwm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/kwm_heads.sv
// Per-track length and read-position table, one read port, flop based.
// Depends on kwm_pkg (heads_cmd_t).
module kwm_heads #(
  parameter int NUM_TRACKS  = kwm_pkg::NUM_TRACKS_DEF,
  parameter int TRACK_DEPTH = kwm_pkg::TRACK_DEPTH_DEF,
  parameter int TW          = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1,
  parameter int PW          = $clog2(TRACK_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  kwm_pkg::heads_cmd_t cmd,
  input  logic [TW-1:0]       idx,
  output logic [PW-1:0]       rd_len,
  output logic [PW-1:0]       rd_pos
);

  logic [PW-1:0] len_q [NUM_TRACKS];
  logic [PW-1:0] pos_q [NUM_TRACKS];

  assign rd_len = len_q[idx];
  assign rd_pos = pos_q[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TRACKS; i++) begin
        len_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < NUM_TRACKS; i++) begin
        len_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else if (cmd.rewind) begin
      for (int i = 0; i < NUM_TRACKS; i++) begin
        pos_q[i] <= '0;
      end
    end else begin
      if (cmd.inc_len) begin
        len_q[idx] <= len_q[idx] + PW'(1);
      end
      if (cmd.inc_pos) begin
        pos_q[idx] <= pos_q[idx] + PW'(1);
      end
    end
  end

endmodule

FILE: rtl/kway_time_merge_unit.sv
// K-way time merge over per-track event stores; uses kwm_pkg, kwm_heads and kwm_ram.
// Per item: load writes the store; rewind/clear/root register their result directly;
// event take scans the heads of the tracks in use (one head read per cycle through the
// store read port and one shared compare); a stalled result holds the block until taken.
// s_tready is low until the result is registered: no new item is taken before then.
// Reset (rst, synchronous): lengths and positions zero, root pending, tracks_in_use 16.
module kway_time_merge_unit #(
  parameter int NUM_TRACKS  = kwm_pkg::NUM_TRACKS_DEF,
  parameter int TRACK_DEPTH = kwm_pkg::TRACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: tracks_in_use
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // track[3:0], event_time[35:4], event_tag[67:36], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_track[3:0], out_time[35:4], out_tag[67:36], zero pad
  output logic [2:0]  m_tuser    // status[2:0]
);

  localparam int TW    = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam int CW    = $clog2(NUM_TRACKS + 1);
  localparam int PW    = $clog2(TRACK_DEPTH + 1);
  localparam int DEPTH = NUM_TRACKS * TRACK_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FINISH = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state;

  logic        in_acc;
  logic [3:0]  in_track;
  logic [31:0] in_time;
  logic [31:0] in_tag;
  kwm_pkg::op_t in_op;

  assign in_acc   = s_tvalid && s_tready;
  assign in_track = s_tdata[3:0];
  assign in_time  = s_tdata[35:4];
  assign in_tag   = s_tdata[67:36];
  assign in_op    = kwm_pkg::op_t'(s_tuser);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration and merge control
  logic [4:0]  tracks_in_use;
  logic        root_pending;
  logic [CW-1:0] n_eff;

  // latched load item
  logic [3:0]  track_q;
  logic [31:0] time_q;
  logic [31:0] tag_q;

  // scan state: counter, in-flight RAM read, running minimum
  logic [CW-1:0] scan_i;
  logic          pend_v;
  logic [TW-1:0] pend_idx;
  logic          found;
  logic [TW-1:0] best_idx;
  logic [31:0]   best_time;
  logic [31:0]   best_tag;

  // result staged before the output register
  kwm_pkg::status_t res_status;
  logic [3:0]  res_track;
  logic [31:0] res_time;
  logic [31:0] res_tag;

  // head table and store
  kwm_pkg::heads_cmd_t heads_cmd;
  logic [TW-1:0] heads_idx;
  logic [PW-1:0] rd_len;
  logic [PW-1:0] rd_pos;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic          ram_re;
  logic [63:0]   ram_rdata;
  logic          load_full;
  logic          scan_live;
  logic          head_ok;
  logic          out_free;

  // saturate the register to the number of stores
  assign n_eff = (32'(tracks_in_use) > NUM_TRACKS) ? CW'(NUM_TRACKS) : CW'(tracks_in_use);

  always_comb begin
    unique case (state)
      S_LOAD:   heads_idx = TW'(track_q);
      S_FINISH: heads_idx = best_idx;
      default:  heads_idx = scan_i[TW-1:0];
    endcase
  end

  // store address: track base plus length (append) or read position (head)
  assign ram_addr = AW'(AW'(heads_idx) * AW'(TRACK_DEPTH))
                  + ((state == S_LOAD) ? AW'(rd_len) : AW'(rd_pos));

  // a track index past the store count is rejected like a full track
  assign load_full = (32'(track_q) >= NUM_TRACKS) || (32'(rd_len) >= TRACK_DEPTH);
  assign scan_live = (scan_i < n_eff);
  assign head_ok   = scan_live && (rd_pos < rd_len);

  assign ram_we = (state == S_LOAD) && !load_full;
  assign ram_re = (state == S_SCAN) && head_ok;

  always_comb begin
    heads_cmd         = '0;
    heads_cmd.inc_len = ram_we;
    heads_cmd.inc_pos = (state == S_FINISH) && found;
    if (state == S_IDLE && in_acc) begin
      heads_cmd.clear  = (in_op == kwm_pkg::OP_CLEAR);
      heads_cmd.rewind = (in_op == kwm_pkg::OP_REWIND);
    end
  end

  kwm_heads #(
    .NUM_TRACKS  (NUM_TRACKS),
    .TRACK_DEPTH (TRACK_DEPTH),
    .TW          (TW),
    .PW          (PW)
  ) u_heads (
    .clk    (clk),
    .rst    (rst),
    .cmd    (heads_cmd),
    .idx    (heads_idx),
    .rd_len (rd_len),
    .rd_pos (rd_pos)
  );

  // entry: time in the high half, tag in the low half
  kwm_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata ({time_q, tag_q}),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign out_free = !m_tvalid || m_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tracks_in_use <= kwm_pkg::TRACKS_IN_USE_RESET;
      root_pending  <= 1'b1;
      pend_v        <= 1'b0;
      found         <= 1'b0;
      scan_i        <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tracks_in_use <= cfg_data;
      end

      // a new result replaces one leaving in the same cycle
      if (state == S_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            track_q <= in_track;
            time_q  <= in_time;
            tag_q   <= in_tag;
            unique case (in_op) inside
              kwm_pkg::OP_LOAD: begin
                state <= S_LOAD;
              end
              kwm_pkg::OP_TAKE: begin
                if (root_pending) begin
                  root_pending <= 1'b0;
                  res_status   <= kwm_pkg::ST_ROOT;
                  res_track    <= '0;
                  res_time     <= '0;
                  res_tag      <= '0;
                  state        <= S_RESULT;
                end else begin
                  scan_i <= '0;
                  pend_v <= 1'b0;
                  found  <= 1'b0;
                  state  <= S_SCAN;
                end
              end
              kwm_pkg::OP_REWIND, kwm_pkg::OP_CLEAR: begin
                root_pending <= 1'b1;
                res_status   <= kwm_pkg::ST_DONE;
                res_track    <= '0;
                res_time     <= '0;
                res_tag      <= '0;
                state        <= S_RESULT;
              end
            endcase
          end
        end

        S_LOAD: begin
          res_status <= load_full ? kwm_pkg::ST_FULL : kwm_pkg::ST_LOADED;
          res_track  <= track_q;
          res_time   <= time_q;
          res_tag    <= tag_q;
          state      <= S_RESULT;
        end

        S_SCAN: begin
          // issue the head read of track scan_i, compare the one read last cycle
          pend_v   <= ram_re;
          pend_idx <= scan_i[TW-1:0];
          if (scan_live) begin
            scan_i <= scan_i + CW'(1);
          end else if (!pend_v) begin
            state <= S_FINISH;
          end
          // strict less-than keeps ties on the lowest track
          if (pend_v && (!found || ram_rdata[63:32] < best_time)) begin
            found     <= 1'b1;
            best_idx  <= pend_idx;
            best_time <= ram_rdata[63:32];
            best_tag  <= ram_rdata[31:0];
          end
        end

        S_FINISH: begin
          if (found) begin
            res_status <= kwm_pkg::ST_EVENT;
            res_track  <= 4'(best_idx);
            res_time   <= best_time;
            res_tag    <= best_tag;
          end else begin
            res_status <= kwm_pkg::ST_NONE;
            res_track  <= '0;
            res_time   <= '0;
            res_tag    <= '0;
          end
          state <= S_RESULT;
        end

        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      m_tdata <= {4'b0, res_tag, res_time, res_track};
      m_tuser <= res_status;
    end
  end

endmodule

FILE: tb/kwm_checker.sv
`timescale 1ns / 1ps
// Checker for the k-way time merge unit: watches the config, input and result
// channels, keeps its own merge state and compares every result item.
// Depends on kwm_pkg for the operation and status codes.
module kwm_checker #(
  parameter int TRACKS = kwm_pkg::NUM_TRACKS_DEF,
  parameter int DEPTH  = kwm_pkg::TRACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,   // track[3:0], event_time[35:4], event_tag[67:36], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // out_track[3:0], out_time[35:4], out_tag[67:36], zero pad
  input  logic [2:0]  m_tuser,   // status[2:0]
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    kwm_pkg::status_t status;
    logic [3:0]       trk;
    logic [31:0]      tm;
    logic [31:0]      tg;
  } merge_result_t;

  merge_result_t expected_q[$];

  // time in the high half, tag in the low half
  logic [63:0] ev_store [TRACKS*DEPTH];
  int unsigned ev_len [TRACKS];
  int unsigned rd_pos [TRACKS];
  bit          root_due;
  logic [4:0]  tiu;

  function automatic merge_result_t next_merge_result(kwm_pkg::op_t op, logic [3:0] trk,
                                                      logic [31:0] tm, logic [31:0] tg);
    merge_result_t r;
    int unsigned   n;
    bit            found;
    int unsigned   best;
    logic [31:0]   best_t;
    logic [63:0]   e;
    r.status = kwm_pkg::ST_DONE;
    r.trk    = '0;
    r.tm     = '0;
    r.tg     = '0;
    case (op)
      kwm_pkg::OP_LOAD: begin
        r.trk = trk;
        r.tm  = tm;
        r.tg  = tg;
        if (trk >= TRACKS || ev_len[trk] >= DEPTH) begin
          r.status = kwm_pkg::ST_FULL;
        end else begin
          ev_store[trk*DEPTH + ev_len[trk]] = {tm, tg};
          ev_len[trk]++;
          r.status = kwm_pkg::ST_LOADED;
        end
      end
      kwm_pkg::OP_TAKE: begin
        if (root_due) begin
          root_due = 1'b0;
          r.status = kwm_pkg::ST_ROOT;
        end else begin
          n = (tiu > TRACKS) ? TRACKS : tiu;
          found  = 1'b0;
          best   = 0;
          best_t = '0;
          // strict less-than keeps ties on the lowest track
          for (int unsigned i = 0; i < n; i++) begin
            if (rd_pos[i] < ev_len[i]) begin
              e = ev_store[i*DEPTH + rd_pos[i]];
              if (!found || e[63:32] < best_t) begin
                found  = 1'b1;
                best   = i;
                best_t = e[63:32];
              end
            end
          end
          if (found) begin
            e = ev_store[best*DEPTH + rd_pos[best]];
            rd_pos[best]++;
            r.status = kwm_pkg::ST_EVENT;
            r.trk    = best[3:0];
            r.tm     = e[63:32];
            r.tg     = e[31:0];
          end else begin
            r.status = kwm_pkg::ST_NONE;
          end
        end
      end
      default: begin
        if (op == kwm_pkg::OP_CLEAR) begin
          foreach (ev_len[i]) ev_len[i] = 0;
        end
        foreach (rd_pos[i]) rd_pos[i] = 0;
        root_due = 1'b1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    merge_result_t want;
    if (rst) begin
      foreach (ev_len[i]) ev_len[i] = 0;
      foreach (rd_pos[i]) rd_pos[i] = 0;
      root_due = 1'b1;
      tiu      = kwm_pkg::TRACKS_IN_USE_RESET;
      expected_q.delete();
      pending    = 0;
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) tiu = cfg_data;
      if (s_tvalid && s_tready) begin
        expected_q.push_back(next_merge_result(kwm_pkg::op_t'(s_tuser), s_tdata[3:0],
                                               s_tdata[35:4], s_tdata[67:36]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result item: status %0d track %0d time %h tag %h",
                     m_tuser, m_tdata[3:0], m_tdata[35:4], m_tdata[67:36]);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (m_tuser !== want.status || m_tdata[3:0] !== want.trk ||
              m_tdata[35:4] !== want.tm || m_tdata[67:36] !== want.tg) begin
            if (mismatches < 10)
              $display("mismatch exp/got: st %0d/%0d trk %0d/%0d time %h/%h tag %h/%h",
                       want.status, m_tuser, want.trk, m_tdata[3:0],
                       want.tm, m_tdata[35:4], want.tg, m_tdata[67:36]);
            mismatches++;
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

FILE: tb/tb_kway_time_merge_unit.sv
`timescale 1ns / 1ps
// Top of the k-way time merge testbench: clock, reset, stimulus and verdict.
// Depends on kwm_pkg, kway_time_merge_unit and kwm_checker.
module tb_kway_time_merge_unit;

  // settle margin after draining, enough for the slowest item to finish
  localparam int SETTLE = 30;
  // watchdog limit for the whole run, set well above the slowest run with every stall phase
  localparam int LIMIT  = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // track[3:0], event_time[35:4], event_tag[67:36], zero pad
  logic [1:0]  s_tuser = kwm_pkg::OP_LOAD;  // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // out_track[3:0], out_time[35:4], out_tag[67:36], zero pad
  logic [2:0]  m_tuser;        // status[2:0]

  int mismatches;
  int pending;
  int cycle_count = 0;
  int items_sent  = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic [4:0]  cur_tiu = kwm_pkg::TRACKS_IN_USE_RESET;
  logic [31:0] last_time [16];   // per-track time, kept rising so tracks stay sorted

  kway_time_merge_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  kwm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic set_idle(input int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
      default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so back-to-back items keep it up.
  task automatic push_item(input kwm_pkg::op_t op, input logic [3:0] trk,
                           input logic [31:0] tm, input logic [31:0] tg);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {4'h0, tg, tm, trk};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // drain every expected result, then let the block settle
  task automatic wait_quiet;
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_tracks(input logic [4:0] v);
    wait_quiet();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_tiu   = v;
  endtask

  // load one event whose time does not fall below the track's previous one;
  // mostly small steps so ties across and within tracks are common
  task automatic load_sorted(input logic [3:0] trk);
    logic [32:0] nxt;
    if ($urandom_range(7) == 0) nxt = {1'b0, last_time[trk]} + 33'($urandom);
    else                        nxt = {1'b0, last_time[trk]} + 33'($urandom_range(3));
    if (nxt[32]) nxt = 33'h0_FFFF_FFFF;
    last_time[trk] = nxt[31:0];
    push_item(kwm_pkg::OP_LOAD, trk, nxt[31:0], $urandom);
  endtask

  // Mostly clear / load batch / take until exhausted, with loads and rewinds
  // slipped into the merge; the rest is random noise items.
  task automatic run_merge_traffic(input int budget);
    int          stop;
    int          k;
    int          tiu_eff;
    logic [3:0]  trk;
    logic [31:0] base;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      tiu_eff = (cur_tiu > 16) ? 16 : cur_tiu;
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(3) != 0) begin
          push_item(kwm_pkg::OP_CLEAR, 4'($urandom), $urandom, $urandom);
          case ($urandom_range(3))
            0:       base = '0;
            1:       base = 32'hFFFF_FFF0 + $urandom_range(15);
            default: base = $urandom;
          endcase
          foreach (last_time[i]) last_time[i] = base;
        end
        k = $urandom_range(12, 2);
        repeat (k) begin
          // when any track is merged, at least half the loads land on merged tracks
          if (tiu_eff > 0 && $urandom_range(1)) trk = 4'($urandom_range(tiu_eff - 1, 0));
          else                                  trk = 4'($urandom_range(15, 0));
          load_sorted(trk);
        end
        repeat (k + 2) begin
          push_item(kwm_pkg::OP_TAKE, 4'($urandom), $urandom, $urandom);
          if ($urandom_range(3) == 0) begin
            load_sorted(4'($urandom_range(15, 0)));
          end else if ($urandom_range(19) == 0) begin
            push_item(kwm_pkg::OP_REWIND, 4'($urandom), $urandom, $urandom);
          end
        end
      end else begin
        repeat ($urandom_range(4, 1))
          push_item(kwm_pkg::op_t'($urandom_range(3)), 4'($urandom), $urandom, $urandom);
      end
    end
  endtask

  // fill one track to capacity, then push two more that must be rejected
  task automatic fill_track;
    push_item(kwm_pkg::OP_CLEAR, 4'd0, '0, '0);
    for (int i = 0; i < kwm_pkg::TRACK_DEPTH_DEF; i++) begin
      push_item(kwm_pkg::OP_LOAD, 4'd9, 32'(i) * 32'd7, $urandom);
      if (i % 64 == 63) push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);
    end
    push_item(kwm_pkg::OP_LOAD, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(kwm_pkg::OP_LOAD, 4'd9, 32'h0000_0000, 32'h0000_0000);
    repeat (3) push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);
    push_item(kwm_pkg::OP_REWIND, 4'd0, '0, '0);
    repeat (3) push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);
    push_item(kwm_pkg::OP_CLEAR, 4'd0, '0, '0);
  endtask

  initial begin
    logic [4:0] tiu_plan [8];
    tiu_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd9, 5'd17, 5'd2};
    foreach (last_time[i]) last_time[i] = '0;

    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // --- directed, reset value of 16 tracks ---
    set_idle(0);
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);                        // root marker first
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);                        // nothing loaded
    push_item(kwm_pkg::OP_LOAD, 4'd0,  32'hFFFF_FFFF, 32'h0000_0000);  // top time
    push_item(kwm_pkg::OP_LOAD, 4'd15, 32'h0000_0000, 32'hFFFF_FFFF);
    push_item(kwm_pkg::OP_LOAD, 4'd3,  32'hFFFF_FFFF, 32'hA5A5_A5A5);  // ties with track 0
    push_item(kwm_pkg::OP_LOAD, 4'd7,  32'd100, 32'd1);
    push_item(kwm_pkg::OP_LOAD, 4'd7,  32'd100, 32'd2);
    push_item(kwm_pkg::OP_LOAD, 4'd2,  32'd100, 32'd3);                // tie, lower track wins
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);                        // track 15 at time 0
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);                        // track 2
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);                        // track 7 tag 1
    push_item(kwm_pkg::OP_LOAD, 4'd1,  32'd50, 32'h5A5A_5A5A);         // load mid-merge
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);                        // track 0 over track 3
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);                        // exhausted
    push_item(kwm_pkg::OP_REWIND, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);                        // root again
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);                        // replay from the start
    push_item(kwm_pkg::OP_CLEAR, 4'd0, '0, '0);
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);
    push_item(kwm_pkg::OP_TAKE, 4'd0, '0, '0);

    // --- random phases over the register settings and idle patterns ---
    for (int p = 0; p < 8; p++) begin
      set_idle(p % 4);
      write_tracks(tiu_plan[p]);
      run_merge_traffic(62);
      if (p == 1) begin
        set_idle(3);
        write_tracks(5'd16);
        fill_track();
      end
    end

    wait_quiet();
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
